/* rtl/compact_key_value_table_macros.svh */
// ----------------------------------------------------------------------------
// Compact key/value table assertion macros
// Shared concurrent check templates, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMPACT_KEY_VALUE_TABLE_MACROS_SVH
`define COMPACT_KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define KVT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kvt check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define KVT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kvt check failed");

`endif

/* rtl/kvt_pkg.sv */
// ----------------------------------------------------------------------------
// kvt_pkg
// Sizes, codes and entry type shared by the compact key/value table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

    localparam int ENTRIES  = 1024;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        F_INSERT = 2'd0,
        F_LOOKUP = 2'd1,
        F_REMOVE = 2'd2,
        F_NOP    = 2'd3
    } func_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5
    } status_e_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } kv_entry_t;

    // Ring control from the sequencer to the cell row.
    typedef struct packed {
        logic      shift;
        kv_entry_t fb;
    } ring_ctl_t;

endpackage

`default_nettype wire

/* rtl/kvt_cell.sv */
// ----------------------------------------------------------------------------
// kvt_cell
// One stage of the entry ring: holds a key/value pair, loads its neighbor's.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvt_cell
(
    input  wire logic               clk,
    input  wire logic               shift,
    input  wire kvt_pkg::kv_entry_t d,
    output kvt_pkg::kv_entry_t      q
);

    kvt_pkg::kv_entry_t entry_reg;
    kvt_pkg::kv_entry_t entry_next;

    assign entry_next = shift ? d : entry_reg;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

/* rtl/kvt_ctrl.sv */
// ----------------------------------------------------------------------------
// kvt_ctrl
// Scan sequencer at the ring head: compares, rewrites the feedback entry, reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvt_ctrl
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [kvt_pkg::FUNC_W-1:0]    func,
    input  wire logic [kvt_pkg::KEY_W-1:0]     key,
    input  wire logic [kvt_pkg::VAL_W-1:0]     value,
    output logic                               busy,
    output logic                               done,
    output logic [kvt_pkg::STATUS_W-1:0]       status,
    output logic [kvt_pkg::VAL_W-1:0]          read_value,
    output logic [kvt_pkg::CNT_W-1:0]          entry_count,
    output logic                               empty_res,
    input  wire kvt_pkg::kv_entry_t            head,
    output kvt_pkg::ring_ctl_t                 ring
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRAP
    } state_t;

    state_t                          state_reg;
    logic [kvt_pkg::IDX_W-1:0]       k_reg;
    logic [kvt_pkg::CNT_W-1:0]       count_reg;
    kvt_pkg::func_e_t                func_reg;
    logic [kvt_pkg::KEY_W-1:0]       key_reg;
    logic [kvt_pkg::VAL_W-1:0]       val_reg;
    logic                            found_reg;
    logic [kvt_pkg::VAL_W-1:0]       rv_reg;
    kvt_pkg::kv_entry_t              first_reg;
    logic                            done_reg;
    kvt_pkg::status_e_t              status_reg;

    logic scanning;
    logic in_range;
    logic at_tail;
    logic last_k;
    logic hit;

    assign scanning = (state_reg == S_SCAN);
    assign in_range = (kvt_pkg::CNT_W'(k_reg) < count_reg);
    assign at_tail  = (kvt_pkg::CNT_W'(k_reg) == count_reg);
    assign last_k   = (k_reg == kvt_pkg::IDX_W'(kvt_pkg::ENTRIES - 1));
    assign hit      = scanning && in_range && (head.key == key_reg);

    // Feedback into the tail cell: pass the head entry through unless this
    // slot gets rewritten.
    always_comb
    begin
        ring.shift = scanning ||
                     ((state_reg == S_WRAP) && (func_reg == kvt_pkg::F_REMOVE) && found_reg);
        ring.fb    = head;
        case (func_reg)
            kvt_pkg::F_INSERT:
            begin
                if (hit)
                begin
                    ring.fb.value = val_reg;
                end
                else if (scanning && at_tail && !found_reg)
                begin
                    ring.fb.key   = key_reg;
                    ring.fb.value = val_reg;
                end
            end
            kvt_pkg::F_REMOVE:
            begin
                if (hit && (k_reg != '0))
                begin
                    ring.fb = first_reg;
                end
            end
            default:
            begin
                ring.fb = head;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // Pulse done in the cycle after wrap-up.
            done_reg <= (state_reg == S_WRAP);
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        func_reg  <= kvt_pkg::func_e_t'(func);
                        key_reg   <= key;
                        val_reg   <= value;
                        k_reg     <= '0;
                        found_reg <= 1'b0;
                        rv_reg    <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                        if (func_reg == kvt_pkg::F_LOOKUP)
                        begin
                            rv_reg <= head.value;
                        end
                    end
                    if ((func_reg == kvt_pkg::F_REMOVE) && (k_reg == '0))
                    begin
                        first_reg <= head;
                    end
                    if (last_k)
                    begin
                        state_reg <= S_WRAP;
                    end
                end
                S_WRAP:
                begin
                    state_reg <= S_IDLE;
                    case (func_reg)
                        kvt_pkg::F_INSERT:
                        begin
                            if (found_reg)
                            begin
                                status_reg <= kvt_pkg::ST_REPLACED;
                            end
                            else if (count_reg == kvt_pkg::CNT_W'(kvt_pkg::ENTRIES))
                            begin
                                status_reg <= kvt_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_reg <= kvt_pkg::ST_APPENDED;
                                count_reg  <= count_reg + 1'b1;
                            end
                        end
                        kvt_pkg::F_LOOKUP:
                        begin
                            status_reg <= found_reg ? kvt_pkg::ST_FOUND
                                                    : kvt_pkg::ST_NOT_FOUND;
                        end
                        kvt_pkg::F_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                status_reg <= kvt_pkg::ST_REMOVED;
                                count_reg  <= count_reg - 1'b1;
                            end
                            else
                            begin
                                status_reg <= kvt_pkg::ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            status_reg <= kvt_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = rv_reg;
    assign entry_count = count_reg;
    assign empty_res   = (count_reg == '0);

endmodule

`default_nettype wire

/* rtl/compact_key_value_table.sv */
// ----------------------------------------------------------------------------
// compact_key_value_table
// Key/value table of unique keys held in a rotating ring of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with func, key and value while busy is low; the item is taken
//   at that clock edge and busy rises. func selects insert, lookup, remove or no-op.
//   One result comes back per item: done pulses for exactly one cycle with
//   status, read_value, entry_count and empty_res valid in that cycle. The
//   receiver cannot stall; a result not captured in its done cycle is lost.
// Operation:
//   The entries sit in a ring of ENTRIES cells that rotates one step per
//   cycle while an item is worked. The head cell is compared against the key,
//   and the tail cell is loaded with the head entry or with its rewrite. One
//   full turn of the ring, then the wrap-up state, gives done; a successful
//   removal rotates one step more in the wrap-up state to drop the freed
//   head slot. busy is low again when done pulses, so a new item may start
//   in the done cycle; no new item is taken while one is being worked.
// Reset:
//   rst_n clears the entry count and the sequencer; the table is empty. Cell
//   contents are not cleared, and only slots below the count are ever used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "compact_key_value_table_macros.svh"

module compact_key_value_table
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [kvt_pkg::FUNC_W-1:0]    func,
    input  wire logic [kvt_pkg::KEY_W-1:0]     key,
    input  wire logic [kvt_pkg::VAL_W-1:0]     value,
    output logic                               busy,
    output logic                               done,
    output logic [kvt_pkg::STATUS_W-1:0]       status,
    output logic [kvt_pkg::VAL_W-1:0]          read_value,
    output logic [kvt_pkg::CNT_W-1:0]          entry_count,
    output logic                               empty_res
);

    // Cell outputs; cell 0 is the head seen by the sequencer.
    kvt_pkg::kv_entry_t cell_q [kvt_pkg::ENTRIES];
    kvt_pkg::ring_ctl_t ring;

    kvt_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .key         (key),
        .value       (value),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count),
        .empty_res   (empty_res),
        .head        (cell_q[0]),
        .ring        (ring)
    );

    // Build the ring: each cell loads its upper neighbor; the tail loads the
    // feedback entry from the sequencer.
    genvar gi;
    generate
        for (gi = 0; gi < kvt_pkg::ENTRIES; gi++)
        begin : g_cell
            if (gi == kvt_pkg::ENTRIES - 1)
            begin : g_tail
                kvt_cell u_cell
                (
                    .clk   (clk),
                    .shift (ring.shift),
                    .d     (ring.fb),
                    .q     (cell_q[gi])
                );
            end
            else
            begin : g_body
                kvt_cell u_cell
                (
                    .clk   (clk),
                    .shift (ring.shift),
                    .d     (cell_q[gi+1]),
                    .q     (cell_q[gi])
                );
            end
        end
    endgenerate

    // An accepted item keeps the block busy until its result.
    `KVT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    // The result strobe closes the item; the block is ready again.
    `KVT_ASSERT_IMP(a_done_idle, done, !busy)
    // The result strobe does not repeat back to back.
    `KVT_ASSERT_NXT(a_done_single, done, !done)
    // An append always leaves at least one entry.
    `KVT_ASSERT_IMP(a_append_count, done && (status == kvt_pkg::ST_APPENDED), entry_count != '0)

endmodule

`default_nettype wire
